// ===== hdl/itoa_pkg.sv =====
// Shared types, constants, microprogram and digit encoding for the integer-to-text block.
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 32;
    localparam int RADIX_W         = 6;
    localparam int DIGIT_W         = 6;
    localparam int CHAR_W          = 8;
    localparam int PC_W            = 4;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
    localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA   = 8'h57;  // 'a' minus ten
    localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_DIV_GO,
        UOP_DIV_WAIT,
        UOP_STORE,
        UOP_READ,
        UOP_EMIT_MINUS,
        UOP_EMIT_DIGIT,
        UOP_EMIT_NL,
        UOP_EMIT_NUL
    } t_uop;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_BAD,
        C_MORE,
        C_POS,
        C_CNT_NZ
    } t_cond;

    typedef struct packed {
        t_uop            uop;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Status from datapath to sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic div_busy;
        logic bad;
        logic more;
        logic pos;
        logic cnt_nz;
    } t_stat;

    // Control from sequencer to datapath; go means the step completes this cycle.
    typedef struct packed {
        t_uop uop;
        logic go;
    } t_ctrl;

    // Step addresses.
    localparam logic [PC_W-1:0] ST_LOAD   = 4'd0;
    localparam logic [PC_W-1:0] ST_DIVGO  = 4'd1;
    localparam logic [PC_W-1:0] ST_DIVWT  = 4'd2;
    localparam logic [PC_W-1:0] ST_STORE  = 4'd3;
    localparam logic [PC_W-1:0] ST_SIGN   = 4'd4;
    localparam logic [PC_W-1:0] ST_MINUS  = 4'd5;
    localparam logic [PC_W-1:0] ST_READ   = 4'd6;
    localparam logic [PC_W-1:0] ST_DIGIT  = 4'd7;
    localparam logic [PC_W-1:0] ST_NL     = 4'd8;
    localparam logic [PC_W-1:0] ST_NUL    = 4'd9;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            ST_LOAD:  w = '{UOP_LOAD,       C_BAD,    ST_NUL};
            ST_DIVGO: w = '{UOP_DIV_GO,     C_NEVER,  ST_LOAD};
            ST_DIVWT: w = '{UOP_DIV_WAIT,   C_NEVER,  ST_LOAD};
            ST_STORE: w = '{UOP_STORE,      C_MORE,   ST_DIVGO};
            ST_SIGN:  w = '{UOP_NONE,       C_POS,    ST_READ};
            ST_MINUS: w = '{UOP_EMIT_MINUS, C_NEVER,  ST_LOAD};
            ST_READ:  w = '{UOP_READ,       C_NEVER,  ST_LOAD};
            ST_DIGIT: w = '{UOP_EMIT_DIGIT, C_CNT_NZ, ST_READ};
            ST_NL:    w = '{UOP_EMIT_NL,    C_ALWAYS, ST_LOAD};
            ST_NUL:   w = '{UOP_EMIT_NUL,   C_ALWAYS, ST_LOAD};
            default:  w = '{UOP_NONE,       C_ALWAYS, ST_LOAD};
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = (d < DEC_DIGITS) ? (CHAR_ZERO + {2'b00, d}) : (CHAR_ALPHA + {2'b00, d});
        return c;
    endfunction

endpackage

// ===== hdl/itoa_if.sv =====
// Valid/ready channel interfaces: integer input, character output, radix write.
interface itoa_val_if #(
    parameter int W = itoa_pkg::VALUE_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] value;
    modport source(output valid, output value, input ready);
    modport sink(input valid, input value, output ready);
endinterface

interface itoa_chr_if;
    logic                          valid;
    logic                          ready;
    logic [itoa_pkg::CHAR_W-1:0]   character;
    logic                          last;
    modport source(output valid, output character, output last, input ready);
    modport sink(input valid, input character, input last, output ready);
endinterface

interface itoa_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [itoa_pkg::RADIX_W-1:0]  radix;
    modport source(output valid, output radix, input ready);
    modport sink(input valid, input radix, output ready);
endinterface

// ===== hdl/integer_to_ascii_radix_core.sv =====
// Top level: signed integer to ASCII text in a base from 2 to 36.
//
//  channel  dir  payload              handshake
//  i_in     in   value (signed)       valid/ready, accept when both high
//  o_out    out  character, last      valid/ready, one register stage
//  i_cfg    in   radix (6 bits)       valid/ready, ready always high
//
// One item at a time. Each digit runs the shared bit-serial divider, then the
// digits are emitted, after a minus sign for a negative value and followed by a
// newline; a bad base emits a single NUL character instead.
// Output stalls hold the sequencer on the emitting step. Reset sets radix to 10.
module integer_to_ascii_radix_core #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = itoa_pkg::MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itoa_val_if.sink   i_in,
    itoa_chr_if.source o_out,
    itoa_cfg_if.sink   i_cfg
);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    logic [itoa_pkg::RADIX_W-1:0]  r_radix;
    logic [VALUE_WIDTH-1:0]        r_quot;
    logic [CW-1:0]                 r_cnt;
    logic                          r_neg;
    logic                          r_out_valid;
    logic [itoa_pkg::CHAR_W-1:0]   r_out_char;
    logic                          r_out_last;

    itoa_pkg::t_stat               stat;
    itoa_pkg::t_ctrl               ctrl;
    logic [VALUE_WIDTH-1:0]        in_bits;
    logic [VALUE_WIDTH-1:0]        magnitude;
    logic [CW-1:0]                 cnt_dec;
    logic                          div_start;
    logic                          div_busy;
    logic [VALUE_WIDTH-1:0]        div_quot;
    logic [itoa_pkg::DIGIT_W-1:0]  div_rem;
    logic                          ram_we;
    logic                          ram_re;
    logic [itoa_pkg::DIGIT_W-1:0]  ram_rdata;
    logic                          emit;
    logic                          out_busy;

    // Configuration
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itoa_pkg::RADIX_RESET;
        end else if (i_cfg.valid) begin
            r_radix <= i_cfg.radix;
        end
    end

    // Sequencer
    assign out_busy      = r_out_valid && !o_out.ready;
    assign stat.in_valid = i_in.valid;
    assign stat.out_busy = out_busy;
    assign stat.div_busy = div_busy;
    assign stat.bad      = (r_radix < itoa_pkg::BASE_MIN) || (r_radix > itoa_pkg::BASE_MAX);
    assign stat.more     = (div_quot != '0) && (r_cnt != CW'(MAX_DIGITS - 1));
    assign stat.pos      = !r_neg;
    assign stat.cnt_nz   = (r_cnt != '0);

    itoa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    assign i_in.ready = (ctrl.uop == itoa_pkg::UOP_LOAD);

    // Datapath
    assign in_bits   = i_in.value;
    // Unsigned magnitude: the most negative value maps to 2^(W-1) exactly.
    assign magnitude = in_bits[VALUE_WIDTH-1] ? (~in_bits + 1'b1) : in_bits;
    assign cnt_dec   = r_cnt - 1'b1;
    assign div_start = ctrl.go && (ctrl.uop == itoa_pkg::UOP_DIV_GO);
    assign ram_we    = ctrl.go && (ctrl.uop == itoa_pkg::UOP_STORE);
    assign ram_re    = ctrl.go && (ctrl.uop == itoa_pkg::UOP_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_neg <= 1'b0;
        end else if (ctrl.go) begin
            case (ctrl.uop)
                itoa_pkg::UOP_LOAD: begin
                    r_cnt <= '0;
                    r_neg <= in_bits[VALUE_WIDTH-1];
                end
                itoa_pkg::UOP_STORE: r_cnt <= r_cnt + 1'b1;
                itoa_pkg::UOP_READ:  r_cnt <= cnt_dec;
                default:             r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.go && ctrl.uop == itoa_pkg::UOP_LOAD) begin
            r_quot <= magnitude;
        end else if (ram_we) begin
            r_quot <= div_quot;
        end
    end

    itoa_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_quot),
        .i_divisor  (r_radix),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    itoa_ram #(
        .WIDTH (itoa_pkg::DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (div_rem),
        .i_re    (ram_re),
        .i_raddr (cnt_dec[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Output register
    assign emit = ctrl.go && ((ctrl.uop == itoa_pkg::UOP_EMIT_MINUS)
                           || (ctrl.uop == itoa_pkg::UOP_EMIT_DIGIT)
                           || (ctrl.uop == itoa_pkg::UOP_EMIT_NL)
                           || (ctrl.uop == itoa_pkg::UOP_EMIT_NUL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            case (ctrl.uop)
                itoa_pkg::UOP_EMIT_MINUS: begin
                    r_out_char <= itoa_pkg::CHAR_MINUS;
                    r_out_last <= 1'b0;
                end
                itoa_pkg::UOP_EMIT_DIGIT: begin
                    r_out_char <= itoa_pkg::digit_char(ram_rdata);
                    r_out_last <= 1'b0;
                end
                itoa_pkg::UOP_EMIT_NL: begin
                    r_out_char <= itoa_pkg::CHAR_NEWLINE;
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_char <= itoa_pkg::CHAR_NUL;
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

`ifndef NO_ASSERTIONS
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !out_busy)
        else $error("pending character overwritten");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_DIGITS))
        else $error("digit count past store depth");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_cnt != '0))
        else $error("digit read with empty store");

    a_last_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (r_out_char == itoa_pkg::CHAR_NEWLINE || r_out_char == itoa_pkg::CHAR_NUL))
        else $error("last flag on a non-terminating character");
`endif
endmodule

// ===== hdl/itoa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
    parameter int WIDTH = itoa_pkg::DIGIT_W,
    parameter int DEPTH = itoa_pkg::MAX_DIGITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/itoa_div.sv =====
// Restoring divider, one quotient bit per cycle, narrow divisor.
module itoa_div #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [VALUE_WIDTH-1:0]        i_dividend,
    input  logic [itoa_pkg::RADIX_W-1:0]  i_divisor,
    output logic                          o_busy,
    output logic [VALUE_WIDTH-1:0]        o_quot,
    output logic [itoa_pkg::DIGIT_W-1:0]  o_rem
);
    localparam int BW = $clog2(VALUE_WIDTH + 1);

    logic                          r_busy;
    logic [BW-1:0]                 r_bits;
    logic [VALUE_WIDTH-1:0]        r_q;
    logic [itoa_pkg::DIGIT_W-1:0]  r_rem;
    logic [itoa_pkg::DIGIT_W:0]    trial;
    logic                          ge;

    // Remainder stays below the divisor (a 6-bit value), so the shifted trial fits 7 bits.
    assign trial = {r_rem, r_q[VALUE_WIDTH-1]};
    assign ge    = (trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bits <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_bits <= BW'(VALUE_WIDTH);
        end else if (r_busy) begin
            r_bits <= r_bits - 1'b1;
            if (r_bits == BW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[VALUE_WIDTH-2:0], ge};
            r_rem <= ge ? itoa_pkg::DIGIT_W'(trial - {1'b0, i_divisor})
                        : trial[itoa_pkg::DIGIT_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// ===== hdl/itoa_seq.sv =====
// Microcode sequencer: step counter, control ROM, hold and jump logic.
module itoa_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  itoa_pkg::t_stat i_stat,
    output itoa_pkg::t_ctrl o_ctrl
);
    logic [itoa_pkg::PC_W-1:0] r_pc;
    logic [itoa_pkg::PC_W-1:0] n_pc;
    itoa_pkg::t_uword          word;
    logic                      hold;
    logic                      take;

    assign word = itoa_pkg::ucode(r_pc);

    // A step waits in place until its resource is available.
    always_comb begin
        case (word.uop) inside
            itoa_pkg::UOP_LOAD:     hold = !i_stat.in_valid;
            itoa_pkg::UOP_DIV_WAIT: hold = i_stat.div_busy;
            itoa_pkg::UOP_EMIT_MINUS, itoa_pkg::UOP_EMIT_DIGIT,
            itoa_pkg::UOP_EMIT_NL, itoa_pkg::UOP_EMIT_NUL:
                                    hold = i_stat.out_busy;
            default:                hold = 1'b0;
        endcase
    end

    always_comb begin
        unique case (word.cond)
            itoa_pkg::C_NEVER:  take = 1'b0;
            itoa_pkg::C_ALWAYS: take = 1'b1;
            itoa_pkg::C_BAD:    take = i_stat.bad;
            itoa_pkg::C_MORE:   take = i_stat.more;
            itoa_pkg::C_POS:    take = i_stat.pos;
            itoa_pkg::C_CNT_NZ: take = i_stat.cnt_nz;
            default:            take = 1'b0;
        endcase
    end

    always_comb begin
        if (hold) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = word.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= itoa_pkg::ST_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.uop = word.uop;
    assign o_ctrl.go  = !hold;
endmodule
